// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the stereo meter checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SBM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sbm checker: property failed");

// Check a property on every clock edge, reset cycles included.
`define SBM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("sbm checker: property failed");

`endif

// File: src/sbm_pkg.sv
// ---------------------------------------------------------------------------
// sbm_pkg
// Types and constants of the stereo bar meter with peak hold.
// ---------------------------------------------------------------------------
package sbm_pkg;

   // LED chain length and field widths
   localparam int NUM_LEDS   = 60;
   localparam int LEVEL_W    = 6;
   localparam int HOLD_W     = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 5;

   typedef logic [LEVEL_W-1:0]    level_type;
   typedef logic [HOLD_W-1:0]     hold_type;
   typedef logic [NUM_LEDS-1:0]   led_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // Highest level and LED number
   localparam level_type LEVEL_MAX = level_type'(NUM_LEDS);

   // Register reset values
   localparam logic     DECAY_MODE_RST = 1'b1;
   localparam hold_type HOLD_TICKS_RST = hold_type'(20);

   // Register indexes
   localparam csr_index_type CSR_PEAK_DECAY_MODE = csr_index_type'(0);
   localparam csr_index_type CSR_HOLD_TICKS      = csr_index_type'(1);

   // One meter tick
   typedef struct packed {
      level_type left_level;
      level_type right_level;
   } req_data_type;

   // One display update
   typedef struct packed {
      led_type   left_leds;
      led_type   right_leds;
      level_type left_bar;
      level_type right_bar;
      level_type left_peak;
      level_type right_peak;
   } rsp_data_type;

   // Per-channel meter state
   typedef struct packed {
      level_type last;
      level_type bar;
      level_type peak;
      hold_type  hold;
   } channel_state_type;

endpackage

// File: src/stereo_bar_meter_peak_hold_core.sv
// ---------------------------------------------------------------------------
// stereo_bar_meter_peak_hold_core
// Stereo LED bar meter with falling bar and peak hold with decay.
// ---------------------------------------------------------------------------
// Each accepted tick carries a left and right level in LED steps (above 60
// saturates to 60) and yields exactly one result: a 60-LED pattern per
// channel (thermometer bar plus one peak dot) together with the bar length
// and peak LED number. A tick passes an input register, then one pass of
// per-channel update logic loads the result register and the channel state,
// so the block takes one tick per clock cycle unless the result stalls. The
// result is registered in the result register from the input register; a
// stalled result holds the input register and then the input. Registers are
// written through the csr_ channel, which is always ready; write them only
// while no tick is in flight.
// ---------------------------------------------------------------------------
module stereo_bar_meter_peak_hold_core
   import sbm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_data_type  req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_data_type  rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_wdata
);

   logic              decay_mode_ff;
   hold_type          hold_ticks_ff;
   logic              req_valid_ff;
   req_data_type      req_data_ff;
   channel_state_type left_ff, right_ff;
   channel_state_type left_in, right_in;
   logic              rsp_valid_ff;
   rsp_data_type      rsp_data_ff;
   rsp_data_type      rsp_data_in;
   logic              advance;

   // Advance one channel by one tick
   function automatic channel_state_type channel_update(
      input channel_state_type cur,
      input level_type         raw,
      input logic              decay,
      input hold_type          hold_load
   );
      channel_state_type nxt;
      level_type         lvl;
      lvl = (raw > LEVEL_MAX) ? LEVEL_MAX : raw;
      nxt = cur;
      // release one LED against the previous level, then attack
      if (nxt.bar > cur.last) begin
         nxt.bar = nxt.bar - level_type'(1);
      end
      if (lvl > nxt.bar) begin
         nxt.bar = lvl;
      end
      nxt.last = lvl;
      // capture a new peak
      if (lvl > cur.peak) begin
         nxt.peak = lvl;
         nxt.hold = hold_load;
      end
      // count down the hold, then drop the peak every second tick
      if (decay) begin
         if (nxt.hold != '0) begin
            nxt.hold = nxt.hold - hold_type'(1);
         end else if (nxt.peak != '0) begin
            nxt.peak = nxt.peak - level_type'(1);
            nxt.hold = hold_type'(1);
         end
      end
      return nxt;
   endfunction

   // Build bar thermometer plus peak dot
   function automatic led_type led_pattern(input level_type bar, input level_type peak);
      led_type   pat;
      level_type pos;
      pat = '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
         pos    = level_type'(i + 1);
         pat[i] = (pos <= bar) || (pos == peak);
      end
      return pat;
   endfunction

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Update both channels and format the result
   always_comb begin
      left_in  = channel_update(left_ff, req_data_ff.left_level,
                                decay_mode_ff, hold_ticks_ff);
      right_in = channel_update(right_ff, req_data_ff.right_level,
                                decay_mode_ff, hold_ticks_ff);
      rsp_data_in.left_leds  = led_pattern(left_in.bar, left_in.peak);
      rsp_data_in.right_leds = led_pattern(right_in.bar, right_in.peak);
      rsp_data_in.left_bar   = left_in.bar;
      rsp_data_in.right_bar  = right_in.bar;
      rsp_data_in.left_peak  = left_in.peak;
      rsp_data_in.right_peak = right_in.peak;
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_mode_ff <= DECAY_MODE_RST;
         hold_ticks_ff <= HOLD_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PEAK_DECAY_MODE: decay_mode_ff <= csr_wdata[0];
            CSR_HOLD_TICKS:      hold_ticks_ff <= csr_wdata[HOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Hold the accepted tick in the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
   end

   // Commit channel state and load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            left_ff      <= left_in;
            right_ff     <= right_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: src/sbm_checker.sv
// ---------------------------------------------------------------------------
// sbm_checker
// Port-level checks of the stereo meter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sbm_checker
   import sbm_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input req_data_type  req_data,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input rsp_data_type  rsp_data,
   input logic          csr_valid,
   input logic          csr_ready,
   input csr_index_type csr_index,
   input csr_data_type  csr_wdata
);

   // Reset empties the result register
   `SBM_ASSERT_ALWAYS(a_rst_empty, clock, reset |=> !rsp_valid)

   // A stalled result stays put
   `SBM_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // Counts stay inside the LED chain
   `SBM_ASSERT(a_count_range, clock, reset,
      rsp_valid |-> rsp_data.left_bar <= LEVEL_MAX && rsp_data.right_bar <= LEVEL_MAX &&
                    rsp_data.left_peak <= LEVEL_MAX && rsp_data.right_peak <= LEVEL_MAX)

   // First LED agrees with the counts
   `SBM_ASSERT(a_first_led, clock, reset,
      rsp_valid |-> rsp_data.left_leds[0] ==
                       (rsp_data.left_bar != '0 || rsp_data.left_peak == level_type'(1)) &&
                    rsp_data.right_leds[0] ==
                       (rsp_data.right_bar != '0 || rsp_data.right_peak == level_type'(1)))

endmodule

bind stereo_bar_meter_peak_hold_core sbm_checker u_sbm_checker (.*);
